[design/swmt_pkg.sv]
package swmt_pkg;

  // Fixed field widths of the channels
  localparam int CHAN_W = 8;
  localparam int SAMPLE_W = 16;
  localparam int FILT_W = 16;

  // Default sizing of the core
  localparam int CHANNELS_DEF = 256;
  localparam int WINDOW_DEF = 5;
  localparam int SAMPLE_BITS_DEF = 16;

endpackage

[design/swmt_in_if.sv]
// Sample channel: one channel index and one raw sample per transaction
interface swmt_in_if;
  logic                          valid;
  logic                          ready;
  logic [swmt_pkg::CHAN_W-1:0]   channel;
  logic [swmt_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

[design/swmt_out_if.sv]
// Result channel: echoed channel index and the window median
interface swmt_out_if;
  logic                        valid;
  logic                        ready;
  logic [swmt_pkg::CHAN_W-1:0] channel_out;
  logic [swmt_pkg::FILT_W-1:0] filtered;

  modport source (output valid, output channel_out, output filtered, input ready);
  modport sink (input valid, input channel_out, input filtered, output ready);
endinterface

[design/swmt_row_ram.sv]
// Row store: one write port, one read port, registered read data
module swmt_row_ram #(
  parameter int DEPTH = swmt_pkg::CHANNELS_DEF,
  parameter int WIDTH = swmt_pkg::WINDOW_DEF * swmt_pkg::SAMPLE_BITS_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/sorted_window_median_tracker_core.sv]
// Per-channel sorted-window median tracker.
// in_ch carries (channel, sample); out_ch returns (channel_out, filtered), one
// result transaction for every sample transaction, in order. Each channel owns a
// sorted row of WINDOW entries in a row-wide RAM. A sample below the middle entry
// replaces the largest entry, one above it replaces the smallest; the row is then
// re-sorted by a single comparator doing one compare-and-swap per cycle.
// A sample equal to the median skips the re-sort and write-back; a changed row takes k
// compare-and-swap steps, k in 1 .. WINDOW-1; a channel at or beyond CHANNELS
// gives a result with filtered as zero.
// in_ch.ready is high only between items, so the next sample can be taken in the
// cycle after the result is registered.
// After reset the RAM is swept to zero, one row per cycle, before the first
// sample is accepted.
// The result waits in an output register; a new sample may be accepted while it
// is still held. If out_ch stalls, the next result waits in the finish step
// until the register drains, and no further sample is taken meanwhile.
module sorted_window_median_tracker_core #(
  parameter int CHANNELS = swmt_pkg::CHANNELS_DEF,
  parameter int WINDOW = swmt_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = swmt_pkg::SAMPLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  swmt_in_if.sink    in_ch,
  swmt_out_if.source out_ch
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ROW_W = WINDOW * SAMPLE_BITS;
  localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(CHANNELS - 1);
  localparam logic [IDX_W-1:0] MID_IDX = IDX_W'(WINDOW / 2);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [IDX_W-1:0] LAST_PAIR = IDX_W'(WINDOW - 2);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_CMP,
    ST_SORT,
    ST_WRITE,
    ST_FINISH
  } state_t;

  state_t                                   state_r;
  logic [ADDR_W-1:0]                        clr_r;
  logic [ADDR_W-1:0]                        addr_r;
  logic [swmt_pkg::CHAN_W-1:0]              chan_r;
  logic                                     in_range_r;
  logic [SAMPLE_BITS-1:0]                   value_r;
  logic [WINDOW-1:0][SAMPLE_BITS-1:0]       list_r;
  logic [IDX_W-1:0]                         j_r;
  logic                                     down_r;
  logic                                     out_valid_r;
  logic [swmt_pkg::CHAN_W-1:0]              out_chan_r;
  logic [swmt_pkg::FILT_W-1:0]              out_filt_r;

  logic                                     in_take;
  logic                                     out_take;
  logic                                     chan_ok;
  logic [ADDR_W+swmt_pkg::CHAN_W-1:0]       chan_ext;
  logic [31:0]                              samp_ext;
  logic [31:0]                              mid_ext;
  logic [IDX_W-1:0]                         j_p1;
  logic [SAMPLE_BITS-1:0]                   op_a;
  logic [SAMPLE_BITS-1:0]                   op_b;
  logic                                     cmp_gt;
  logic                                     cmp_eq;
  logic                                     ram_we;
  logic [ADDR_W-1:0]                        ram_waddr;
  logic [ROW_W-1:0]                         ram_wdata;
  logic [ROW_W-1:0]                         ram_rdata;

  // Handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take = in_ch.valid && in_ch.ready;
  assign out_take = out_valid_r && out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.channel_out = out_chan_r;
  assign out_ch.filtered = out_filt_r;

  // Input field shaping
  assign chan_ok = 32'(in_ch.channel) < 32'(CHANNELS);
  assign chan_ext = (ADDR_W + swmt_pkg::CHAN_W)'(in_ch.channel);
  assign samp_ext = 32'(in_ch.sample);
  assign mid_ext = 32'(list_r[MID_IDX]);
  assign j_p1 = j_r + IDX_W'(1);

  // Shared comparator operand select
  always_comb begin
    unique case (state_r)
      ST_CMP: begin
        op_a = list_r[MID_IDX];
        op_b = value_r;
      end
      default: begin
        op_a = list_r[j_r];
        op_b = list_r[j_p1];
      end
    endcase
  end

  assign cmp_gt = op_a > op_b;
  assign cmp_eq = op_a == op_b;

  // RAM write port: clearing sweep or row write-back
  assign ram_we = (state_r == ST_CLEAR) || (state_r == ST_WRITE);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : addr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : ROW_W'(list_r);

  swmt_row_ram #(
    .DEPTH (CHANNELS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_take),
    .raddr (chan_ext[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // held result taken; the finish step reloads the register itself
      if (out_take && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + ADDR_W'(1);
          if (clr_r == LAST_ROW) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            chan_r <= in_ch.channel;
            addr_r <= chan_ext[ADDR_W-1:0];
            in_range_r <= chan_ok;
            value_r <= samp_ext[SAMPLE_BITS-1:0];
            state_r <= chan_ok ? ST_LOAD : ST_FINISH;
          end
        end
        ST_LOAD: begin
          list_r <= ram_rdata;
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          // median above the sample: drop the largest, bubble toward the front
          priority if (cmp_eq) begin
            state_r <= ST_FINISH;
          end else if (cmp_gt) begin
            list_r[LAST_IDX] <= value_r;
            down_r <= 1'b1;
            j_r <= LAST_PAIR;
            state_r <= (WINDOW > 1) ? ST_SORT : ST_WRITE;
          end else begin
            list_r[0] <= value_r;
            down_r <= 1'b0;
            j_r <= '0;
            state_r <= (WINDOW > 1) ? ST_SORT : ST_WRITE;
          end
        end
        ST_SORT: begin
          // one compare-and-swap per cycle; stop once a pair is in order
          if (cmp_gt) begin
            list_r[j_r] <= list_r[j_p1];
            list_r[j_p1] <= list_r[j_r];
            if (down_r ? (j_r == '0) : (j_r == LAST_PAIR)) begin
              state_r <= ST_WRITE;
            end else begin
              j_r <= down_r ? (j_r - IDX_W'(1)) : j_p1;
            end
          end else begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_chan_r <= chan_r;
            out_filt_r <= in_range_r ? mid_ext[swmt_pkg::FILT_W-1:0] : '0;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/swmt_median_checker.sv]
`timescale 1ns / 100ps

// Watches both channels, tracks every channel's sorted window and checks
// each result transaction against the oldest predicted median.
module swmt_median_checker #(
  parameter int CHANNELS = swmt_pkg::CHANNELS_DEF,
  parameter int WINDOW = swmt_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = swmt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [swmt_pkg::CHAN_W-1:0]   in_channel,
  input  logic [swmt_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [swmt_pkg::CHAN_W-1:0]   out_channel_out,
  input  logic [swmt_pkg::FILT_W-1:0]   out_filtered,
  output int                            mismatch_count,
  output int                            pending_count,
  output int                            checked_count
);

  localparam int MID = WINDOW / 2;

  typedef struct packed {
    logic [swmt_pkg::CHAN_W-1:0] channel;
    logic [swmt_pkg::FILT_W-1:0] median;
  } median_result_t;

  // Shadow copy of every channel's sorted window
  logic [SAMPLE_BITS-1:0] window_rows [CHANNELS][WINDOW];
  median_result_t medians_due [$];

  // Apply one sample to its channel's window, return the new median
  function automatic median_result_t track_median(
    input logic [swmt_pkg::CHAN_W-1:0]   ch,
    input logic [swmt_pkg::SAMPLE_W-1:0] raw
  );
    logic [SAMPLE_BITS-1:0] row [WINDOW];
    logic [SAMPLE_BITS-1:0] val;
    logic [SAMPLE_BITS-1:0] key;
    int b;
    median_result_t res;
    res.channel = ch;
    res.median = '0;
    if (int'(ch) < CHANNELS) begin
      // narrow entries drop the sample's high bits
      val = SAMPLE_BITS'(raw);
      row = window_rows[ch];
      if (val != row[MID]) begin
        // below the middle replaces the top, above replaces the bottom
        if (val < row[MID]) row[WINDOW-1] = val;
        else row[0] = val;
        for (int a = 1; a < WINDOW; a++) begin
          key = row[a];
          b = a;
          while (b > 0 && row[b-1] > key) begin
            row[b] = row[b-1];
            b--;
          end
          row[b] = key;
        end
        window_rows[ch] = row;
      end
      // wide entries report only their low bits
      res.median = swmt_pkg::FILT_W'(row[MID]);
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input median_result_t want,
                               input median_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch (%s): expected ch=%0d median=%0d, got ch=%0d median=%0d",
               $realtime, what, want.channel, want.median, got.channel, got.median);
  endtask

  // Predict on accepted samples, compare on accepted results
  always @(posedge clk) begin
    median_result_t got;
    median_result_t want;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++)
        for (int w = 0; w < WINDOW; w++)
          window_rows[c][w] = '0;
      medians_due.delete();
    end else begin
      if (in_valid && in_ready)
        medians_due.push_back(track_median(in_channel, in_sample));
      if (out_valid && out_ready) begin
        got.channel = out_channel_out;
        got.median = out_filtered;
        checked_count++;
        if (medians_due.size() == 0) begin
          want = '0;
          flag_mismatch("no transaction outstanding", want, got);
        end else begin
          want = medians_due.pop_front();
          if (got.channel != want.channel || got.median != want.median)
            flag_mismatch("field compare", want, got);
        end
      end
    end
    pending_count = medians_due.size();
  end

endmodule

[dv/sorted_window_median_tracker_core_test.sv]
`timescale 1ns / 100ps

module sorted_window_median_tracker_core_test;

  localparam int RANDOM_ITEMS = 700;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIRECTED_ITEMS = 23;

  // {channel, sample}: zero-equal, climbs to the top, drops back, bit patterns
  localparam logic [23:0] DIRECTED [DIRECTED_ITEMS] = '{
    24'h00_0000, 24'h00_FFFF, 24'h00_FFFF, 24'h00_FFFF, 24'h00_0001,
    24'h00_0001, 24'h00_8000, 24'h00_0000, 24'h00_0000, 24'hFF_FFFF,
    24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_0000,
    24'h55_AAAA, 24'hAA_5555, 24'h01_7FFF, 24'h01_7FFF, 24'h01_7FFE,
    24'h80_0001, 24'h80_0002, 24'h80_0003
  };

  localparam logic [7:0] HOT_CHANNELS [8] = '{
    8'd0, 8'd255, 8'd1, 8'd128, 8'h55, 8'hAA, 8'd7, 8'd200
  };

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic clk;
  logic rst_n;
  int   items_sent;
  int   cycle_count;
  bit   long_hold_done;
  int   mismatches;
  int   pending;
  int   checked;

  swmt_in_if  in_bus ();
  swmt_out_if out_bus ();

  sorted_window_median_tracker_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  swmt_median_checker median_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_bus.valid),
    .in_ready        (in_bus.ready),
    .in_channel      (in_bus.channel),
    .in_sample       (in_bus.sample),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_channel_out (out_bus.channel_out),
    .out_filtered    (out_bus.filtered),
    .mismatch_count  (mismatches),
    .pending_count   (pending),
    .checked_count   (checked)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Offer one sample and hold it until the block takes it
  task automatic send_item(input logic [swmt_pkg::CHAN_W-1:0] ch,
                           input logic [swmt_pkg::SAMPLE_W-1:0] smp);
    in_bus.valid <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample <= smp;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  // Sample source: directed items, then random bursts
  initial begin
    int burst_left;
    int gap;
    logic [swmt_pkg::CHAN_W-1:0] ch;
    logic [swmt_pkg::SAMPLE_W-1:0] smp;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.channel <= '0;
    in_bus.sample <= '0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_item(DIRECTED[i][23:16], DIRECTED[i][15:0]);

    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // mostly a few busy channels so windows fill with real data
      if ($urandom_range(0, 9) < 7) ch = HOT_CHANNELS[$urandom_range(0, 7)];
      else ch = 8'($urandom);
      case ($urandom_range(0, 4))
        0: smp = 16'($urandom);
        1: smp = 16'($urandom_range(0, 7));      // tiny range: frequent ties
        2: smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        3: smp = 16'hFFF8 | 16'($urandom_range(0, 7));
        default: smp = 16'($urandom_range(1000, 1010));
      endcase
      send_item(ch, smp);
      burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, 12);
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
    end
    in_bus.valid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples (%0d directed) and checked %0d median results;",
             items_sent, DIRECTED_ITEMS, checked);
    $display("output side held off once for %0d cycles, %0d mismatches.",
             LONG_HOLD, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result sink: random stall patterns plus one long hold-off
  initial begin
    rx_mode_t mode;
    int span;
    long_hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && items_sent >= HOLD_AFTER) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(5, 60);
      repeat (span) begin
        case (mode)
          RX_OPEN:   out_bus.ready <= 1'b1;
          RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_bus.ready <= ($urandom_range(0, 3) == 0);
          default:   out_bus.ready <= ~out_bus.ready;
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
